@@ hdl/tli_pkg.sv @@
// shared types and constants of the table linear interpolator
`default_nettype none

package tli_pkg;

    localparam int KEY_W   = 16;
    localparam int VALUE_W = 16;
    localparam int INDEX_W = 4;
    localparam int COUNT_W = 5;

    // quotient is 16 bits wide, two bits resolved per divider step
    localparam int DIV_BITS_PER_STEP = 2;
    localparam int DIV_STEPS         = KEY_W / DIV_BITS_PER_STEP;
    localparam int DIV_STEP_W        = $clog2(DIV_STEPS);

    typedef logic [KEY_W-1:0]          key_t;
    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [INDEX_W-1:0]        index_t;
    typedef logic [COUNT_W-1:0]        count_t;

    typedef enum logic
    {
        KIND_QUERY = 1'b0,
        KIND_LOAD  = 1'b1
    } kind_t;

    typedef enum logic [2:0]
    {
        STATUS_INTERP = 3'd0,
        STATUS_LOW    = 3'd1,
        STATUS_HIGH   = 3'd2,
        STATUS_EMPTY  = 3'd3,
        STATUS_LOADED = 3'd4
    } status_t;

    typedef struct packed
    {
        kind_t  kind;
        key_t   query_key;
        index_t entry_index;
        key_t   entry_key;
        value_t entry_value;
    } item_t;

    typedef struct packed
    {
        value_t  result_value;
        status_t status;
    } result_t;

    // breakpoint write broadcast to every cell
    typedef struct packed
    {
        logic   en;
        index_t index;
        key_t   key;
        value_t value;
    } load_cmd_t;

    // search token passed from cell to cell
    typedef struct packed
    {
        logic   valid;
        logic   have_prev;
        logic   found;
        key_t   query_key;
        key_t   x0;
        value_t y0;
        key_t   x1;
        value_t y1;
    } scan_token_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_SCAN,
        S_MULT,
        S_DIVIDE,
        S_FINISH
    } state_t;

endpackage

`default_nettype wire

@@ hdl/tli_stream_if.sv @@
// valid/ready channel carrying one payload per request
`default_nettype none

interface tli_stream_if #(parameter type payload_t = logic);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);

endinterface

`default_nettype wire

@@ hdl/table_linear_interpolator_unit.sv @@
// top level: breakpoint table with piecewise linear interpolation
`default_nettype none

// Breakpoint table of TABLE_DEPTH key/value pairs held in a row of cells.
// A load request (kind 1) writes one cell and answers with status "entry
// loaded" from the finish state; an index at or beyond TABLE_DEPTH
// writes nothing. A query request (kind 0) sends a search token down the
// cell row, one cell per cycle, looking for the first of the first
// entry_count cells whose key is above the query key; entries past that
// count are ignored. Clamped answers pass from the row end to the finish
// state; an interpolated answer goes through the registered 16x17 product,
// the multiply state, the two-bit-per-step divider and the finish state.
// With entry_count at zero a query answers "empty table" from the finish
// state. One request is worked on at a time; the finished result sits in
// an output register, so the next request is taken while it waits.
// entry_count is written through cfg and must only change while idle.
module table_linear_interpolator_unit
    import tli_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    tli_stream_if.sink    item,
    tli_stream_if.source  result,
    tli_stream_if.sink    cfg
);

    state_t state_reg;
    state_t state_next;

    count_t count_reg;

    // fsm controls
    logic   accept_ready;
    logic   div_start;
    logic   finish_load;
    logic   accept;

    // search chain
    load_cmd_t            load;
    scan_token_t          chain [TABLE_DEPTH+1];
    logic [TABLE_DEPTH:0] chain_valid;
    logic [TABLE_DEPTH-1:0] cell_active;
    scan_token_t          scan_out;

    // arithmetic path
    key_t                 dx;
    logic signed [16:0]   dy;
    logic signed [33:0]   product_full;
    logic signed [32:0]   product_reg;
    logic [32:0]          product_mag;
    key_t                 den_reg;
    value_t               y0_reg;
    logic                 neg_reg;
    logic                 div_done;
    key_t                 div_quotient;
    logic                 div_rem_nonzero;
    logic [16:0]          quot_mag;
    logic signed [17:0]   quot_s;
    logic signed [18:0]   sum_s;
    value_t               sat_value;

    // result staging and output register
    value_t               stage_value_reg;
    status_t              stage_status_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    result_t              out_payload_reg;

    // ------------------------------------------------------------------
    // configuration register, always ready
    // ------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg.valid)
        begin
            count_reg <= cfg.payload;
        end
    end

    // ------------------------------------------------------------------
    // request acceptance
    // ------------------------------------------------------------------
    assign item.ready = accept_ready;
    assign accept     = item.valid && accept_ready;

    assign load.en    = accept && (item.payload.kind == KIND_LOAD);
    assign load.index = item.payload.entry_index;
    assign load.key   = item.payload.entry_key;
    assign load.value = item.payload.entry_value;

    // token enters cell 0 only for a query on a non-empty table
    always_comb
    begin
        chain[0]           = '0;
        chain[0].valid     = accept && (item.payload.kind == KIND_QUERY) && (count_reg != '0);
        chain[0].query_key = item.payload.query_key;
    end

    // ------------------------------------------------------------------
    // cell row; a count above the depth simply enables every cell
    // ------------------------------------------------------------------
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        assign cell_active[i] = (int'(count_reg) > i);

        tli_cell #(
            .CELL_INDEX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .load      (load),
            .active    (cell_active[i]),
            .token_in  (chain[i]),
            .token_out (chain[i+1])
        );
    end

    for (genvar j = 0; j <= TABLE_DEPTH; j++)
    begin : g_valid
        assign chain_valid[j] = chain[j].valid;
    end

    assign scan_out = chain[TABLE_DEPTH];

    // ------------------------------------------------------------------
    // state machine
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        accept_ready = 1'b0;
        div_start    = 1'b0;
        finish_load  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                accept_ready = 1'b1;
                if (item.valid)
                begin
                    if ((item.payload.kind == KIND_QUERY) && (count_reg != '0))
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_out.valid)
                begin
                    if (scan_out.found && scan_out.have_prev)
                    begin
                        state_next = S_MULT;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_MULT:
            begin
                div_start  = 1'b1;
                state_next = S_DIVIDE;
            end
            S_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    finish_load = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // slope product: x0 <= query < x1 holds after the search
    // ------------------------------------------------------------------
    assign dx           = scan_out.query_key - scan_out.x0;
    assign dy           = 17'(scan_out.y1) - 17'(scan_out.y0);
    assign product_full = $signed({1'b0, dx}) * dy;

    // divide magnitudes, round toward minus infinity afterwards
    assign product_mag = product_reg[32] ? 33'(-product_reg) : 33'(product_reg);

    tli_divider u_divider (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (div_start),
        .dividend    (product_mag[2*KEY_W-1:0]),
        .divisor     (den_reg),
        .done        (div_done),
        .quotient    (div_quotient),
        .rem_nonzero (div_rem_nonzero)
    );

    always_comb
    begin
        // only a negative quotient with a remainder moves one step down
        quot_mag = {1'b0, div_quotient} + 17'(neg_reg && div_rem_nonzero);
        quot_s   = neg_reg ? -$signed({1'b0, quot_mag}) : $signed({1'b0, quot_mag});
        sum_s    = {{3{y0_reg[VALUE_W-1]}}, y0_reg} + {quot_s[17], quot_s};
        // saturation guard, the sum stays between y0 and y1 anyway
        if (sum_s > 19'sd32767)
        begin
            sat_value = 16'sh7fff;
        end
        else if (sum_s < -19'sd32768)
        begin
            sat_value = 16'sh8000;
        end
        else
        begin
            sat_value = sum_s[VALUE_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_value_reg  <= '0;
            stage_status_reg <= (item.payload.kind == KIND_LOAD) ? STATUS_LOADED : STATUS_EMPTY;
        end
        else if ((state_reg == S_SCAN) && scan_out.valid)
        begin
            if (!scan_out.found)
            begin
                // no key above the query: last valid entry
                stage_value_reg  <= scan_out.y0;
                stage_status_reg <= STATUS_HIGH;
            end
            else if (!scan_out.have_prev)
            begin
                // query below the first key
                stage_value_reg  <= scan_out.y1;
                stage_status_reg <= STATUS_LOW;
            end
            else
            begin
                stage_status_reg <= STATUS_INTERP;
            end
            product_reg <= product_full[32:0];
            den_reg     <= scan_out.x1 - scan_out.x0;
            y0_reg      <= scan_out.y0;
        end
        else if ((state_reg == S_DIVIDE) && div_done)
        begin
            stage_value_reg <= sat_value;
        end

        if (state_reg == S_MULT)
        begin
            neg_reg <= product_reg[32];
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_comb
    begin
        if (finish_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish_load)
        begin
            out_payload_reg.result_value <= stage_value_reg;
            out_payload_reg.status       <= stage_status_reg;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_payload_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------

    // only one search token travels the row at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(chain_valid) <= 1)
    else $error("more than one search token in the cell row");

    // a token reaching the end of the row is always awaited
    assert property (@(posedge clk) disable iff (!rst_n)
        scan_out.valid |-> (state_reg == S_SCAN))
    else $error("search token finished outside the scan state");

    // the search leaves a positive key span for the divider
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVIDE) |-> (den_reg != '0))
    else $error("zero divisor during interpolation");

    // divider finishes only while the state machine waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIVIDE))
    else $error("divider done outside the divide state");

endmodule

`default_nettype wire

@@ hdl/tli_cell.sv @@
// one breakpoint cell: holds a key/value pair and advances the search token
`default_nettype none

module tli_cell
    import tli_pkg::*;
#(
    parameter int CELL_INDEX = 0
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  load_cmd_t   load,
    input  logic        active,
    input  scan_token_t token_in,
    output scan_token_t token_out
);

    key_t        key_reg;
    value_t      value_reg;
    scan_token_t token_reg;
    scan_token_t token_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= '0;
            value_reg <= '0;
        end
        else if (load.en && (int'(load.index) == CELL_INDEX))
        begin
            key_reg   <= load.key;
            value_reg <= load.value;
        end
    end

    // first active key above the query closes the search
    always_comb
    begin
        token_next = token_in;
        if (token_in.valid && active && !token_in.found)
        begin
            if (key_reg > token_in.query_key)
            begin
                token_next.found = 1'b1;
                token_next.x1    = key_reg;
                token_next.y1    = value_reg;
            end
            else
            begin
                token_next.have_prev = 1'b1;
                token_next.x0        = key_reg;
                token_next.y0        = value_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_reg <= '0;
        end
        else
        begin
            token_reg <= token_next;
        end
    end

    assign token_out = token_reg;

endmodule

`default_nettype wire

@@ hdl/tli_divider.sv @@
// radix-4 restoring divider for a 16-bit quotient
`default_nettype none

module tli_divider
    import tli_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [2*KEY_W-1:0]   dividend,
    input  key_t                 divisor,
    output logic                 done,
    output key_t                 quotient,
    output logic                 rem_nonzero
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_STEP_W-1:0] step_reg;
    key_t                  rem_reg;
    key_t                  quo_reg;
    key_t                  div_reg;
    key_t                  rem_next;
    key_t                  quo_next;
    logic [KEY_W:0]        trial;

    // upper half of the dividend is below the divisor, so it seeds the remainder
    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        trial    = '0;
        for (int b = 0; b < DIV_BITS_PER_STEP; b++)
        begin
            trial    = {rem_next, quo_next[KEY_W-1]};
            quo_next = {quo_next[KEY_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                trial       = trial - {1'b0, div_reg};
                quo_next[0] = 1'b1;
            end
            rem_next = trial[KEY_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= DIV_STEP_W'(DIV_STEPS - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[2*KEY_W-1:KEY_W];
            quo_reg <= dividend[KEY_W-1:0];
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done        = done_reg;
    assign quotient    = quo_reg;
    assign rem_nonzero = (rem_reg != '0);

endmodule

`default_nettype wire
